// File: rtl/ttcd_pkg.sv
// ----------------------------------------------------------------------------
// ttcd_pkg
// Shared types and constants for the touch threshold crossing dispatch block.
// ----------------------------------------------------------------------------
`default_nettype none

package ttcd_pkg;

    localparam int MAX_BINDINGS = 16;
    localparam int MAX_SENSORS  = 128;

    localparam int CNT_W  = $clog2(MAX_BINDINGS + 1);
    localparam int BIDX_W = (MAX_BINDINGS > 1) ? $clog2(MAX_BINDINGS) : 1;
    localparam int SIDX_W = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    localparam int IN_TDATA_W  = 96;
    localparam int OUT_TDATA_W = 40;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_BIND  = 2'd1,
        OP_LOAD  = 2'd2,
        OP_EVAL  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_ACK   = 2'd0,
        KIND_FIRED = 2'd1,
        KIND_NONE  = 2'd2
    } kind_t;

    typedef struct packed {
        op_t                op;
        logic [6:0]         sensor;
        logic signed [15:0] threshold;
        logic               rising;
        logic [31:0]        handler_id;
        logic signed [15:0] old_value;
        logic signed [15:0] new_value;
        logic [7:0]         sensor_count;
        logic               load_ok;
    } cmd_t;

    typedef struct packed {
        logic [6:0]         sensor;
        logic signed [15:0] threshold;
        logic               rising;
        logic [31:0]        id;
    } bind_t;

endpackage

`default_nettype wire

// File: rtl/ttcd_front.sv
// ----------------------------------------------------------------------------
// ttcd_front
// Accepts stream words, decodes the command and queues it for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module ttcd_front
    import ttcd_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0] s_axis_tdata,
    input  wire logic [1:0]            s_axis_tuser,
    output logic                       q_valid,
    output cmd_t                       q_cmd,
    input  wire logic                  q_pop
);

    cmd_t              q_mem [QDEPTH];
    logic [QPTR_W-1:0] wptr_reg, wptr_next;
    logic [QPTR_W-1:0] rptr_reg, rptr_next;
    logic [QPTR_W:0]   cnt_reg, cnt_next;
    logic              push;
    logic              pop;
    cmd_t              dec;

    always_comb begin
        dec.op           = op_t'(s_axis_tuser);
        dec.sensor       = s_axis_tdata[6:0];
        dec.threshold    = s_axis_tdata[22:7];
        dec.rising       = s_axis_tdata[23];
        dec.handler_id   = s_axis_tdata[55:24];
        dec.old_value    = s_axis_tdata[71:56];
        dec.new_value    = s_axis_tdata[87:72];
        dec.sensor_count = s_axis_tdata[95:88];
        dec.load_ok      = ({1'b0, s_axis_tdata[6:0]} < 8'(MAX_SENSORS));
    end

    assign s_axis_tready = (cnt_reg < (QPTR_W+1)'(QDEPTH));
    assign q_valid       = (cnt_reg != '0);
    assign q_cmd         = q_mem[rptr_reg];
    assign push          = s_axis_tvalid && s_axis_tready;
    assign pop           = q_pop && q_valid;

    always_comb begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (push) begin
            wptr_next = (wptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (pop) begin
            rptr_next = (rptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wptr_reg] <= dec;
        end
    end

endmodule

`default_nettype wire

// File: rtl/ttcd_back.sv
// ----------------------------------------------------------------------------
// ttcd_back
// Executes queued commands: binding table, sample store, binding walk and
// the result output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ttcd_back
    import ttcd_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  q_valid,
    input  wire cmd_t  q_cmd,
    output logic       q_pop,
    output logic       m_valid,
    input  wire logic  m_ready,
    output kind_t      m_kind,
    output logic [31:0] m_id,
    output logic       m_full,
    output logic       m_last
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_ACK  = 4'b0010,
        S_WALK = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   bcnt_reg, bcnt_next;
    logic [CNT_W-1:0]   widx_reg, widx_next;
    logic [7:0]         fcnt_reg, fcnt_next;
    logic               ack_full_reg, ack_full_next;
    logic               s1_v_reg, s1_v_next;
    bind_t              s1_reg, s1_next;
    logic               pend_v_reg, pend_v_next;
    logic [31:0]        pend_id_reg, pend_id_next;
    logic               m_valid_reg, m_valid_next;
    kind_t              m_kind_reg, m_kind_next;
    logic [31:0]        m_id_reg, m_id_next;
    logic               m_full_reg, m_full_next;
    logic               m_last_reg, m_last_next;

    bind_t              bind_mem [MAX_BINDINGS];
    logic [31:0]        smp_mem [MAX_SENSORS];
    logic [31:0]        smp_rd_reg;

    logic               bind_we;
    logic               smp_we;
    logic               rd_en;
    bind_t              bind_rd;
    logic               out_free;
    logic               stall;
    logic               s1_match;
    logic signed [15:0] ov, nv, lo, hi, thr;
    logic               in_frame;

    assign bind_rd  = bind_mem[widx_reg[BIDX_W-1:0]];
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        ov       = $signed(smp_rd_reg[31:16]);
        nv       = $signed(smp_rd_reg[15:0]);
        thr      = $signed(s1_reg.threshold);
        lo       = (ov < nv) ? ov : nv;
        hi       = (ov > nv) ? ov : nv;
        in_frame = ({1'b0, s1_reg.sensor} < fcnt_reg)
                   && ({1'b0, s1_reg.sensor} < 8'(MAX_SENSORS));
        s1_match = in_frame && (lo < thr) && (thr <= hi)
                   && ((nv > ov) == s1_reg.rising);
    end

    assign stall = s1_v_reg && s1_match && pend_v_reg && !out_free;

    always_comb begin
        state_next    = state_reg;
        bcnt_next     = bcnt_reg;
        widx_next     = widx_reg;
        fcnt_next     = fcnt_reg;
        ack_full_next = ack_full_reg;
        s1_v_next     = s1_v_reg;
        s1_next       = s1_reg;
        pend_v_next   = pend_v_reg;
        pend_id_next  = pend_id_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_kind_next   = m_kind_reg;
        m_id_next     = m_id_reg;
        m_full_next   = m_full_reg;
        m_last_next   = m_last_reg;
        q_pop         = 1'b0;
        bind_we       = 1'b0;
        smp_we        = 1'b0;
        rd_en         = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (q_valid) begin
                    q_pop         = 1'b1;
                    ack_full_next = 1'b0;
                    unique case (q_cmd.op)
                        OP_CLEAR: begin
                            bcnt_next  = '0;
                            state_next = S_ACK;
                        end
                        OP_BIND: begin
                            if (bcnt_reg < CNT_W'(MAX_BINDINGS)) begin
                                bind_we   = 1'b1;
                                bcnt_next = bcnt_reg + 1'b1;
                            end else begin
                                ack_full_next = 1'b1;
                            end
                            state_next = S_ACK;
                        end
                        OP_LOAD: begin
                            smp_we     = q_cmd.load_ok;
                            state_next = S_ACK;
                        end
                        OP_EVAL: begin
                            fcnt_next  = q_cmd.sensor_count;
                            widx_next  = '0;
                            s1_v_next  = 1'b0;
                            state_next = S_WALK;
                        end
                        default: state_next = S_ACK;
                    endcase
                end
            end
            S_ACK: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_kind_next  = KIND_ACK;
                    m_id_next    = '0;
                    m_full_next  = ack_full_reg;
                    m_last_next  = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_WALK: begin
                if (!stall) begin
                    if (s1_v_reg && s1_match) begin
                        if (pend_v_reg) begin
                            m_valid_next = 1'b1;
                            m_kind_next  = KIND_FIRED;
                            m_id_next    = pend_id_reg;
                            m_full_next  = 1'b0;
                            m_last_next  = 1'b0;
                        end
                        pend_v_next  = 1'b1;
                        pend_id_next = s1_reg.id;
                    end
                    if (widx_reg < bcnt_reg) begin
                        rd_en     = 1'b1;
                        s1_v_next = 1'b1;
                        s1_next   = bind_rd;
                        widx_next = widx_reg + 1'b1;
                    end else begin
                        s1_v_next = 1'b0;
                        if (!s1_v_reg) begin
                            state_next = S_DONE;
                        end
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_kind_next  = pend_v_reg ? KIND_FIRED : KIND_NONE;
                    m_id_next    = pend_v_reg ? pend_id_reg : '0;
                    m_full_next  = 1'b0;
                    m_last_next  = 1'b1;
                    pend_v_next  = 1'b0;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            bcnt_reg    <= '0;
            s1_v_reg    <= 1'b0;
            pend_v_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            bcnt_reg    <= bcnt_next;
            s1_v_reg    <= s1_v_next;
            pend_v_reg  <= pend_v_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        widx_reg     <= widx_next;
        fcnt_reg     <= fcnt_next;
        ack_full_reg <= ack_full_next;
        s1_reg       <= s1_next;
        pend_id_reg  <= pend_id_next;
        m_kind_reg   <= m_kind_next;
        m_id_reg     <= m_id_next;
        m_full_reg   <= m_full_next;
        m_last_reg   <= m_last_next;
    end

    always_ff @(posedge aclk) begin
        if (bind_we) begin
            bind_mem[bcnt_reg[BIDX_W-1:0]] <= '{sensor:     q_cmd.sensor,
                                                threshold:  q_cmd.threshold,
                                                rising:     q_cmd.rising,
                                                id:         q_cmd.handler_id};
        end
    end

    // sample store: old reading high half, new reading low half
    always_ff @(posedge aclk) begin
        if (smp_we) begin
            smp_mem[q_cmd.sensor[SIDX_W-1:0]] <= {q_cmd.old_value, q_cmd.new_value};
        end
        if (rd_en) begin
            smp_rd_reg <= smp_mem[bind_rd.sensor[SIDX_W-1:0]];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_kind  = m_kind_reg;
    assign m_id    = m_id_reg;
    assign m_full  = m_full_reg;
    assign m_last  = m_last_reg;

    a_bcnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        bcnt_reg <= CNT_W'(MAX_BINDINGS))
        else $error("binding count beyond table size");

    a_s1_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_v_reg |-> (state_reg == S_WALK))
        else $error("compare stage busy outside walk");

    a_pend_scope: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_v_reg |-> (state_reg == S_WALK || state_reg == S_DONE))
        else $error("pending match left over after evaluate");

    a_widx_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WALK) |-> (widx_reg <= bcnt_reg))
        else $error("walk index past binding count");

    a_none_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_kind_reg == KIND_NONE) |-> m_last_reg)
        else $error("none result without last");

endmodule

`default_nettype wire

// File: rtl/touch_threshold_crossing_dispatch.sv
// ----------------------------------------------------------------------------
// touch_threshold_crossing_dispatch
// Binding table of touch threshold crossings; evaluate emits the callback id
// of each binding whose sensor crossed its threshold in the bound direction.
//
// Channel  Dir  Ports           Word
// input    in   s_axis_*        command word: tuser = cmd, tdata = operands
// result   out  m_axis_*        ack, fired callback id or none; tlast = last
//
// Clear, bind and load pass from the command queue through the idle and ack states
// to the result output register. Evaluate walks the stored bindings at one binding
// per cycle while the output does not stall, through the registered sample read,
// then drains the compare stage and writes a final word.
// Reset empties the binding table; samples stay undefined until loaded.
// A two-word command queue keeps input flowing while results stall; the walk
// holds on a stalled m_axis_tready.
// ----------------------------------------------------------------------------
`default_nettype none

module touch_threshold_crossing_dispatch
    import ttcd_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // sensor_index, threshold, rising, handler_id, old_value, new_value,
    // sensor_count
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // cmd
    input  wire logic [1:0]             s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // fired_id, table_full, zero pad
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    // kind
    output logic [1:0]                  m_axis_tuser,
    output logic                        m_axis_tlast
);

    logic        q_valid;
    cmd_t        q_cmd;
    logic        q_pop;
    kind_t       m_kind;
    logic [31:0] m_id;
    logic        m_full;

    ttcd_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_valid       (q_valid),
        .q_cmd         (q_cmd),
        .q_pop         (q_pop)
    );

    ttcd_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_cmd   (q_cmd),
        .q_pop   (q_pop),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .m_kind  (m_kind),
        .m_id    (m_id),
        .m_full  (m_full),
        .m_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {{(OUT_TDATA_W - 33){1'b0}}, m_full, m_id};
    assign m_axis_tuser = m_kind;

endmodule

`default_nettype wire
